// ===== hdl/ipu_pkg.sv =====
// Shared types and constants for the integer pixel upscaler.
`default_nettype none

package ipu_pkg;

    // Fixed field widths.
    localparam int FACTOR_W = 7;
    localparam int IWIDTH_W = 12;
    localparam int CFG_W    = 12;
    localparam int PIX_W    = 24;
    localparam int PAD_W    = 2;

    // Default sizes of the line store and the factor range.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_FACTOR = 100;

    // Depth of the result queue in front of the master port.
    localparam int OUT_DEPTH = 3;

    // Word kinds.
    typedef enum logic [1:0] {
        ST_STORED   = 2'd0,
        ST_REJECTED = 2'd1,
        ST_GIVEN    = 2'd2,
        ST_IDLE     = 2'd3
    } status_t;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_PULL = 1'b1
    } action_t;

    typedef enum logic {
        REG_SCALE_FACTOR = 1'b0,
        REG_INPUT_WIDTH  = 1'b1
    } reg_idx_t;

    // Result attributes decided by the control logic.
    typedef struct packed {
        status_t          status;
        logic             row_end;
        logic [PAD_W-1:0] pad;
    } result_t;

    // One word of the result queue.
    typedef struct packed {
        result_t          res;
        logic [PIX_W-1:0] pix;
    } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/ipu_line_store.sv =====
// Line store: one write port and one registered read port.
`default_nettype none

module ipu_line_store #(
    parameter int DEPTH = ipu_pkg::DEF_MAX_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [ipu_pkg::PIX_W-1:0] wr_data,
    input  wire logic                     rd_en,
    input  wire logic [AW-1:0]            rd_addr,
    output logic      [ipu_pkg::PIX_W-1:0] rd_data
);

    logic [ipu_pkg::PIX_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data register holds between reads.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ipu_ctrl.sv =====
// Upscaler control: registers, row counters and line store addressing.
`default_nettype none

module ipu_ctrl #(
    parameter int MAX_WIDTH  = ipu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = ipu_pkg::DEF_MAX_FACTOR,
    parameter int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Register writes
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_addr,
    input  wire logic [ipu_pkg::CFG_W-1:0] cfg_wdata,
    // Accepted word
    input  wire logic                      acc,
    input  wire logic                      action,
    // Line store addressing
    output logic                           wr_en,
    output logic [AW-1:0]                  wr_addr,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    // Result attributes, in the cycle after accept (with the read data)
    output logic                           res_valid,
    output ipu_pkg::result_t               res
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int FW  = $clog2(MAX_FACTOR + 1);
    localparam int FCW = (FW > ipu_pkg::FACTOR_W) ? FW : ipu_pkg::FACTOR_W;
    localparam int WCW = (CW > ipu_pkg::IWIDTH_W) ? CW : ipu_pkg::IWIDTH_W;
    localparam logic [FCW-1:0] MaxF = FCW'(MAX_FACTOR);
    localparam logic [WCW-1:0] MaxW = WCW'(MAX_WIDTH);

    logic [ipu_pkg::FACTOR_W-1:0] sf_reg;
    logic [ipu_pkg::IWIDTH_W-1:0] iw_reg;

    logic [CW-1:0] wc_reg, wc_next;
    logic [CW-1:0] rc_reg, rc_next;
    logic [FW-1:0] cc_reg, cc_next;
    logic [FW-1:0] rr_reg, rr_next;
    logic          held_reg, held_next;

    logic             res_valid_reg;
    ipu_pkg::result_t res_reg, res_next;

    logic [FCW-1:0] sf_ext;
    logic [WCW-1:0] iw_ext;
    logic [FW-1:0]  f_eff;
    logic [CW-1:0]  w_eff;
    logic [1:0]     w_lo, f_lo, bytes_lo;
    logic [CW-1:0]  wc_inc, rc_inc;
    logic [FW-1:0]  cc_inc, rr_inc;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sf_reg <= ipu_pkg::FACTOR_W'(1);
            iw_reg <= ipu_pkg::IWIDTH_W'(1);
        end else if (cfg_we) begin
            case (ipu_pkg::reg_idx_t'(cfg_addr))
                ipu_pkg::REG_SCALE_FACTOR: sf_reg <= cfg_wdata[ipu_pkg::FACTOR_W-1:0];
                ipu_pkg::REG_INPUT_WIDTH:  iw_reg <= cfg_wdata[ipu_pkg::IWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective factor and width, clamped to their legal ranges.
    always_comb begin
        sf_ext = FCW'(sf_reg);
        iw_ext = WCW'(iw_reg);
        if (sf_ext == '0) begin
            f_eff = FW'(1);
        end else if (sf_ext > MaxF) begin
            f_eff = FW'(MAX_FACTOR);
        end else begin
            f_eff = FW'(sf_ext);
        end
        if (iw_ext == '0) begin
            w_eff = CW'(1);
        end else if (iw_ext > MaxW) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(iw_ext);
        end
    end

    // Padding depends only on the low two bits of width times factor times three.
    always_comb begin
        w_lo     = 2'(w_eff);
        f_lo     = 2'(f_eff);
        bytes_lo = 2'(w_lo * f_lo * 2'd3);
    end

    // Next state of the row counters and the result of the accepted word.
    always_comb begin
        wc_next   = wc_reg;
        rc_next   = rc_reg;
        cc_next   = cc_reg;
        rr_next   = rr_reg;
        held_next = held_reg;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        wc_inc    = wc_reg + CW'(1);
        rc_inc    = rc_reg + CW'(1);
        cc_inc    = cc_reg + FW'(1);
        rr_inc    = rr_reg + FW'(1);
        res_next.status  = ipu_pkg::ST_IDLE;
        res_next.row_end = 1'b0;
        res_next.pad     = '0;

        if (acc) begin
            if (ipu_pkg::action_t'(action) == ipu_pkg::ACT_PUSH) begin
                if (held_reg) begin
                    res_next.status = ipu_pkg::ST_REJECTED;
                end else begin
                    res_next.status = ipu_pkg::ST_STORED;
                    wr_en   = 1'b1;
                    wc_next = wc_inc;
                    if (wc_inc >= w_eff) begin
                        wc_next   = '0;
                        held_next = 1'b1;
                        rc_next   = '0;
                        cc_next   = '0;
                        rr_next   = '0;
                    end
                end
            end else if (held_reg) begin
                res_next.status = ipu_pkg::ST_GIVEN;
                rd_en   = 1'b1;
                cc_next = cc_inc;
                if (cc_inc >= f_eff) begin
                    cc_next = '0;
                    rc_next = rc_inc;
                end
                // End of an output row.
                if (rc_next >= w_eff) begin
                    res_next.row_end = 1'b1;
                    res_next.pad     = 2'(2'd0 - bytes_lo);
                    rc_next = '0;
                    cc_next = '0;
                    rr_next = rr_inc;
                    if (rr_inc >= f_eff) begin
                        rr_next   = '0;
                        held_next = 1'b0;
                    end
                end
            end
        end
    end

    assign wr_addr = wc_reg[AW-1:0];
    assign rd_addr = rc_reg[AW-1:0];

    // Counter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg   <= '0;
            rc_reg   <= '0;
            cc_reg   <= '0;
            rr_reg   <= '0;
            held_reg <= 1'b0;
        end else begin
            wc_reg   <= wc_next;
            rc_reg   <= rc_next;
            cc_reg   <= cc_next;
            rr_reg   <= rr_next;
            held_reg <= held_next;
        end
    end

    // Result attributes travel alongside the line store read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== hdl/ipu_out_fifo.sv =====
// Small result queue in front of the master port.
`default_nettype none

module ipu_out_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire ipu_pkg::out_word_t push_word,
    input  wire logic               pop,
    output logic                    not_empty,
    output ipu_pkg::out_word_t      head,
    output logic [1:0]              count
);

    localparam logic [1:0] PtrLast = 2'(ipu_pkg::OUT_DEPTH - 1);

    ipu_pkg::out_word_t mem [ipu_pkg::OUT_DEPTH];

    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_pop;

    // Pointer and fill bookkeeping.
    always_comb begin
        do_pop      = pop && (count_reg != 2'd0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    assign not_empty = (count_reg != 2'd0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

// ===== hdl/integer_pixel_upscaler.sv =====
// Top level of the nearest-neighbor integer pixel upscaler.
//
// The block takes one word per clock while s_tready is high and gives one result
// word per accepted word, in order. A push (tuser 0) stores a pixel in the line
// store; once a full row is held, each pull (tuser 1) returns the next output
// pixel, each stored pixel repeated scale_factor times across and the row
// repeated scale_factor times down; m_tlast marks the end of an output row, and
// that word then carries the pad byte count. A result reaches the master port
// through the line store read and then the result queue. The three-entry result
// queue lets s_tready stay high while up to two results wait; it drops when three
// results are outstanding. Registers are written through cfg_we/cfg_addr/cfg_wdata;
// the user must do so only while the block is idle, which the block does not enforce.
`default_nettype none

module integer_pixel_upscaler #(
    parameter int MAX_WIDTH  = ipu_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = ipu_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Register write port: index 0 scale_factor, 1 input_width
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_addr,
    input  wire logic [ipu_pkg::CFG_W-1:0] cfg_wdata,
    // Input words
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [23:0]               s_tdata,   // in_blue, in_green, in_red
    input  wire logic                      s_tuser,   // action
    // Result words
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [31:0]                    m_tdata,   // out_blue, out_green, out_red,
                                                      // pad_bytes, zero fill
    output logic [1:0]                     m_tuser,   // status
    output logic                           m_tlast    // row_end
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic                       s_acc;
    logic                       wr_en, rd_en;
    logic [AW-1:0]              wr_addr, rd_addr;
    logic [ipu_pkg::PIX_W-1:0]  rd_data;
    logic                       res_valid;
    ipu_pkg::result_t           res;
    ipu_pkg::out_word_t         q_in, q_head;
    logic                       q_not_empty;
    logic [1:0]                 q_count;

    // Room check counts the result already on its way into the queue.
    assign s_tready = (3'(q_count) + 3'(res_valid)) < 3'(ipu_pkg::OUT_DEPTH);
    assign s_acc    = s_tvalid && s_tready;

    ipu_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .AW         (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .acc       (s_acc),
        .action    (s_tuser),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .res_valid (res_valid),
        .res       (res)
    );

    ipu_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pixel data is zero unless an output pixel is given.
    always_comb begin
        q_in.res = res;
        q_in.pix = (res.status == ipu_pkg::ST_GIVEN) ? rd_data : '0;
    end

    ipu_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_word (q_in),
        .pop       (m_tready),
        .not_empty (q_not_empty),
        .head      (q_head),
        .count     (q_count)
    );

    // Master port.
    assign m_tvalid = q_not_empty;
    assign m_tdata  = {6'd0, q_head.res.pad, q_head.pix};
    assign m_tuser  = q_head.res.status;
    assign m_tlast  = q_head.res.row_end;

endmodule

`default_nettype wire
